// ----- rtl/kffst_pkg.sv -----
// ----------------------------------------------------------------------------
// kffst_pkg
// Shared constants, operation codes, the probe type that moves along the
// chain of slot cells and the write type of the keyed first-free slot table.
// ----------------------------------------------------------------------------
package kffst_pkg;

  localparam int NUM_ROWS = 4;
  localparam int NUM_COLS = 8;
  localparam int KEY_BITS = 64;
  localparam int SLOTS    = NUM_ROWS * NUM_COLS;

  localparam int ROW_W = (NUM_ROWS > 1) ? $clog2(NUM_ROWS) : 1;
  localparam int COL_W = (NUM_COLS > 1) ? $clog2(NUM_COLS) : 1;

  localparam logic [1:0] FN_ALLOC   = 2'd0;
  localparam logic [1:0] FN_RELEASE = 2'd1;
  localparam logic [1:0] FN_LOCATE  = 2'd2;
  localparam logic [1:0] FN_QUERY   = 2'd3;

  typedef struct packed {
    logic                act;
    logic [1:0]          func;
    logic [KEY_BITS-1:0] key;
    logic                q_in;
    logic [ROW_W-1:0]    q_row;
    logic [COL_W-1:0]    q_col;
    logic                found;
    logic [ROW_W-1:0]    hit_row;
    logic [COL_W-1:0]    hit_col;
    logic                free;
    logic [ROW_W-1:0]    free_row;
    logic [COL_W-1:0]    free_col;
    logic                occ;
  } probe_t;

  typedef struct packed {
    logic                en;
    logic                set;
    logic [ROW_W-1:0]    row;
    logic [COL_W-1:0]    col;
    logic [KEY_BITS-1:0] key;
  } wr_t;

endpackage

// ----- rtl/kffst_cell.sv -----
// ----------------------------------------------------------------------------
// kffst_cell
// One slot of the table: holds a valid bit and a key, checks the passing
// probe for a key match, a free slot and a slot query, and hands the probe
// to the next cell through its probe register.
// ----------------------------------------------------------------------------
module kffst_cell (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic [kffst_pkg::ROW_W-1:0]   cell_row,
  input  logic [kffst_pkg::COL_W-1:0]   cell_col,
  input  kffst_pkg::probe_t             probe_in,
  input  kffst_pkg::wr_t                wr,
  output kffst_pkg::probe_t             probe_out
);

  logic                           valid_r;
  logic [kffst_pkg::KEY_BITS-1:0] key_r;
  kffst_pkg::probe_t              probe_r;
  kffst_pkg::probe_t              probe_nxt;
  logic                           hit;
  logic                           wr_here;

  assign hit     = valid_r && (key_r == probe_in.key);
  assign wr_here = wr.en && (wr.row == cell_row) && (wr.col == cell_col);

  always_comb begin
    probe_nxt = probe_in;
    if (!probe_in.found && hit) begin
      probe_nxt.found   = 1'b1;
      probe_nxt.hit_row = cell_row;
      probe_nxt.hit_col = cell_col;
    end
    if (!probe_in.free && !valid_r) begin
      probe_nxt.free     = 1'b1;
      probe_nxt.free_row = cell_row;
      probe_nxt.free_col = cell_col;
    end
    if (probe_in.q_in && (probe_in.q_row == cell_row) && (probe_in.q_col == cell_col)) begin
      probe_nxt.occ = valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r     <= 1'b0;
      probe_r.act <= 1'b0;
    end else begin
      probe_r <= probe_nxt;
      if (wr_here) begin
        valid_r <= wr.set;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (wr_here && wr.set) begin
      key_r <= wr.key;
    end
  end

  assign probe_out = probe_r;

endmodule

// ----- rtl/keyed_first_free_slot_table.sv -----
// ----------------------------------------------------------------------------
// keyed_first_free_slot_table
// Slot table with allocate, release, locate and slot query; an item walks
// through a chain of slot cells, one cell per cycle, then the table is
// updated and the result is posted.
// ----------------------------------------------------------------------------
// result path: each cell's probe register, then the pending and the output register
// flow: one item at a time; in_stall holds until the result moves from the
//   pending to the output register; the next item is taken while that result waits
// reset: all slots free at once, keys are left as they are, no clearing pass
module keyed_first_free_slot_table (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_func,
  input  logic [63:0] in_plate_key,
  input  logic [1:0]  in_query_row,
  input  logic [2:0]  in_query_col,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_ok,
  output logic [1:0]  out_slot_row,
  output logic [2:0]  out_slot_col,
  output logic        out_occupied
);

  kffst_pkg::probe_t chain [kffst_pkg::SLOTS+1];
  kffst_pkg::probe_t entry;
  kffst_pkg::probe_t last;
  kffst_pkg::wr_t    wr;

  logic       busy_r, busy_nxt;
  logic       pend_vld_r, pend_vld_nxt;
  logic       pend_ok_r, pend_occ_r;
  logic [1:0] pend_row_r;
  logic [2:0] pend_col_r;
  logic       out_valid_r, out_ok_r, out_occ_r;
  logic [1:0] out_row_r;
  logic [2:0] out_col_r;
  logic       acc_in;
  logic       out_free;
  logic       res_ok, res_occ;
  logic [1:0] res_row;
  logic [2:0] res_col;

  assign acc_in   = in_valid && !busy_r;
  assign in_stall = busy_r;
  assign out_free = !out_valid_r || !out_stall;

  always_comb begin
    entry          = '0;
    entry.act      = acc_in;
    entry.func     = in_func;
    entry.key      = in_plate_key[kffst_pkg::KEY_BITS-1:0];
    entry.q_in     = (in_func == kffst_pkg::FN_QUERY)
                     && (int'(in_query_row) < kffst_pkg::NUM_ROWS)
                     && (int'(in_query_col) < kffst_pkg::NUM_COLS);
    entry.q_row    = kffst_pkg::ROW_W'(in_query_row);
    entry.q_col    = kffst_pkg::COL_W'(in_query_col);
  end

  assign chain[0] = entry;

  for (genvar r = 0; r < kffst_pkg::NUM_ROWS; r++) begin : g_row
    for (genvar c = 0; c < kffst_pkg::NUM_COLS; c++) begin : g_col
      kffst_cell u_cell (
        .clk       (clk),
        .rst_n     (rst_n),
        .cell_row  (kffst_pkg::ROW_W'(r)),
        .cell_col  (kffst_pkg::COL_W'(c)),
        .probe_in  (chain[r*kffst_pkg::NUM_COLS + c]),
        .wr        (wr),
        .probe_out (chain[r*kffst_pkg::NUM_COLS + c + 1])
      );
    end
  end

  assign last = chain[kffst_pkg::SLOTS];

  // commit the table update and form the result when the probe leaves the chain
  always_comb begin
    wr      = '0;
    wr.key  = last.key;
    res_ok  = 1'b0;
    res_row = 2'd0;
    res_col = 3'd0;
    res_occ = 1'b0;
    unique case (last.func)
      kffst_pkg::FN_ALLOC: begin
        if (last.found) begin
          res_ok  = 1'b1;
          res_row = 2'(last.hit_row);
          res_col = 3'(last.hit_col);
        end else if (last.free) begin
          wr.en   = last.act;
          wr.set  = 1'b1;
          wr.row  = last.free_row;
          wr.col  = last.free_col;
          res_ok  = 1'b1;
          res_row = 2'(last.free_row);
          res_col = 3'(last.free_col);
        end
      end
      kffst_pkg::FN_RELEASE: begin
        if (last.found) begin
          wr.en  = last.act;
          wr.set = 1'b0;
          wr.row = last.hit_row;
          wr.col = last.hit_col;
          res_ok = 1'b1;
        end
      end
      kffst_pkg::FN_LOCATE: begin
        if (last.found) begin
          res_ok  = 1'b1;
          res_row = 2'(last.hit_row);
          res_col = 3'(last.hit_col);
        end
      end
      kffst_pkg::FN_QUERY: begin
        res_occ = last.occ;
      end
      default: begin
        res_ok = 1'b0;
      end
    endcase
  end

  always_comb begin
    busy_nxt     = busy_r;
    pend_vld_nxt = pend_vld_r;
    if (acc_in) begin
      busy_nxt = 1'b1;
    end
    if (last.act) begin
      pend_vld_nxt = 1'b1;
    end else if (pend_vld_r && out_free) begin
      pend_vld_nxt = 1'b0;
      busy_nxt     = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      pend_vld_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      busy_r     <= busy_nxt;
      pend_vld_r <= pend_vld_nxt;
      if (out_free) begin
        out_valid_r <= pend_vld_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (last.act) begin
      pend_ok_r  <= res_ok;
      pend_row_r <= res_row;
      pend_col_r <= res_col;
      pend_occ_r <= res_occ;
    end
    if (out_free && pend_vld_r) begin
      out_ok_r  <= pend_ok_r;
      out_row_r <= pend_row_r;
      out_col_r <= pend_col_r;
      out_occ_r <= pend_occ_r;
    end
  end

  assign out_valid    = out_valid_r;
  assign out_ok       = out_ok_r;
  assign out_slot_row = out_row_r;
  assign out_slot_col = out_col_r;
  assign out_occupied = out_occ_r;

  a_probe_needs_busy: assert property (@(posedge clk) disable iff (!rst_n)
    last.act |-> busy_r)
    else $error("probe in chain while block idle");

  a_accept_sets_busy: assert property (@(posedge clk) disable iff (!rst_n)
    acc_in |=> busy_r)
    else $error("busy not set after item taken");

  a_no_pend_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !(pend_vld_r && last.act))
    else $error("probe finished while previous result pending");

  a_write_at_end: assert property (@(posedge clk) disable iff (!rst_n)
    wr.en |-> last.act)
    else $error("table write without finished probe");

  a_ok_occ_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !(out_ok_r && out_occ_r))
    else $error("result has both ok and occupied set");

endmodule

// ----- verif/tb_keyed_first_free_slot_table.sv -----
// ----------------------------------------------------------------------------
// tb_keyed_first_free_slot_table
// Self-checking bench for the keyed slot table. A short directed sequence
// covers empty and full keys, duplicates, failed lookups and corner slots.
// Random traffic then fills the table past capacity and drains it again
// under several sender and receiver idle patterns, with one long receiver
// hold-off. A shadow copy of the slot table predicts every result, and the
// monitor checks each returned item field by field in order.
// ----------------------------------------------------------------------------
module tb_keyed_first_free_slot_table;

  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [1:0]  func;
    logic [63:0] key;
    logic [1:0]  qrow;
    logic [2:0]  qcol;
  } table_op_t;

  typedef struct packed {
    logic       ok;
    logic [1:0] row;
    logic [2:0] col;
    logic       occ;
  } slot_result_t;

  typedef enum int {MODE_FILL, MODE_MIX, MODE_DRAIN} traffic_mode_t;

  localparam int POOL_KEYS   = 36;
  localparam int BURST_ITEMS = 120;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [1:0]  in_func = kffst_pkg::FN_ALLOC;
  logic [63:0] in_plate_key = '0;
  logic [1:0]  in_query_row = '0;
  logic [2:0]  in_query_col = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic        out_ok;
  logic [1:0]  out_slot_row;
  logic [2:0]  out_slot_col;
  logic        out_occupied;

  table_op_t                      pending_ops[$];
  slot_result_t                   expected_results[$];
  table_op_t                      driven_op;
  logic                           shadow_valid[kffst_pkg::SLOTS];
  logic [kffst_pkg::KEY_BITS-1:0] shadow_key[kffst_pkg::SLOTS];
  logic [63:0]                    key_pool[POOL_KEYS];
  int                             send_idle_pct = 0;
  int                             recv_stall_pct = 0;
  logic                           hold_off = 1'b0;
  int                             phase_id = 0;
  int                             issued_cnt = 0;
  int                             accepted_cnt = 0;
  int                             fail_cnt = 0;

  keyed_first_free_slot_table u_top (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_func      (in_func),
    .in_plate_key (in_plate_key),
    .in_query_row (in_query_row),
    .in_query_col (in_query_col),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_ok       (out_ok),
    .out_slot_row (out_slot_row),
    .out_slot_col (out_slot_col),
    .out_occupied (out_occupied)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // shadow table: duplicate check first, then first free slot in row-major order
  function automatic slot_result_t apply_table_op(table_op_t op);
    slot_result_t                   res;
    int                             hit;
    int                             vacant;
    logic [kffst_pkg::KEY_BITS-1:0] k;
    res    = '0;
    hit    = -1;
    vacant = -1;
    k      = op.key[kffst_pkg::KEY_BITS-1:0];
    for (int s = kffst_pkg::SLOTS - 1; s >= 0; s--) begin
      if (shadow_valid[s] && shadow_key[s] == k) hit = s;
      if (!shadow_valid[s]) vacant = s;
    end
    unique case (op.func)
      kffst_pkg::FN_ALLOC: begin
        if (hit < 0 && vacant >= 0) begin
          shadow_valid[vacant] = 1'b1;
          shadow_key[vacant]   = k;
          hit = vacant;
        end
        if (hit >= 0) begin
          res.ok  = 1'b1;
          res.row = 2'(hit / kffst_pkg::NUM_COLS);
          res.col = 3'(hit % kffst_pkg::NUM_COLS);
        end
      end
      kffst_pkg::FN_RELEASE: begin
        if (hit >= 0) begin
          shadow_valid[hit] = 1'b0;
          res.ok = 1'b1;
        end
      end
      kffst_pkg::FN_LOCATE: begin
        if (hit >= 0) begin
          res.ok  = 1'b1;
          res.row = 2'(hit / kffst_pkg::NUM_COLS);
          res.col = 3'(hit % kffst_pkg::NUM_COLS);
        end
      end
      default: begin
        if (op.qrow < kffst_pkg::NUM_ROWS && op.qcol < kffst_pkg::NUM_COLS)
          res.occ = shadow_valid[op.qrow * kffst_pkg::NUM_COLS + op.qcol];
      end
    endcase
    return res;
  endfunction

  task automatic push_op(logic [1:0] func, logic [63:0] key, logic [1:0] qrow,
                         logic [2:0] qcol);
    table_op_t op;
    op.func = func;
    op.key  = key;
    op.qrow = qrow;
    op.qcol = qcol;
    pending_ops.push_back(op);
    issued_cnt++;
  endtask

  task automatic push_random_op(traffic_mode_t mode);
    int          pick;
    int          alloc_lim;
    int          release_lim;
    int          locate_lim;
    logic [1:0]  func;
    logic [63:0] key;
    pick = $urandom_range(99);
    unique case (mode)
      MODE_FILL: begin
        alloc_lim = 80; release_lim = 85; locate_lim = 93;
      end
      MODE_DRAIN: begin
        alloc_lim = 15; release_lim = 75; locate_lim = 88;
      end
      default: begin
        alloc_lim = 35; release_lim = 60; locate_lim = 80;
      end
    endcase
    if (pick < alloc_lim) func = kffst_pkg::FN_ALLOC;
    else if (pick < release_lim) func = kffst_pkg::FN_RELEASE;
    else if (pick < locate_lim) func = kffst_pkg::FN_LOCATE;
    else func = kffst_pkg::FN_QUERY;
    if ($urandom_range(99) < 10) key = {$urandom, $urandom};
    else key = key_pool[$urandom_range(POOL_KEYS - 1)];
    push_op(func, key, 2'($urandom_range(3)), 3'($urandom_range(7)));
  endtask

  task automatic wait_idle();
    while (accepted_cnt != issued_cnt || expected_results.size() != 0)
      @(posedge clk);
  endtask

  // driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        expected_results.push_back(apply_table_op(driven_op));
        accepted_cnt++;
      end
      if (!in_valid || !in_stall) begin
        if (pending_ops.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          driven_op = pending_ops.pop_front();
          in_valid     <= 1'b1;
          in_func      <= driven_op.func;
          in_plate_key <= driven_op.key;
          in_query_row <= driven_op.qrow;
          in_query_col <= driven_op.qcol;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // receiver stall
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      out_stall <= hold_off || ($urandom_range(99) < recv_stall_pct);
    end
  end

  function automatic void check_field(string name, int exp_val, int act_val);
    if (exp_val != act_val) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp_val,
               act_val);
      fail_cnt++;
    end
  endfunction

  // monitor
  always @(posedge clk) begin
    slot_result_t exp_res;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_results.size() == 0) begin
        $display("%0t: unexpected item, expected none, actual ok=%0d row=%0d col=%0d occ=%0d",
                 $time, out_ok, out_slot_row, out_slot_col, out_occupied);
        fail_cnt++;
      end else begin
        exp_res = expected_results.pop_front();
        check_field("ok", exp_res.ok, out_ok);
        check_field("slot_row", exp_res.row, out_slot_row);
        check_field("slot_col", exp_res.col, out_slot_col);
        check_field("occupied", exp_res.occ, out_occupied);
      end
    end
  end

  // long receiver hold-off while the sender keeps offering items
  initial begin
    wait (phase_id == 3);
    repeat (50) @(posedge clk);
    hold_off <= 1'b1;
    repeat (400) @(posedge clk);
    hold_off <= 1'b0;
  end

  initial begin
    #5_000_000;
    $display("Test completed with failures");
    $finish;
  end

  initial begin
    int guard;
    for (int s = 0; s < kffst_pkg::SLOTS; s++) begin
      shadow_valid[s] = 1'b0;
      shadow_key[s]   = '0;
    end
    key_pool[0] = 64'd0;
    key_pool[1] = '1;
    key_pool[2] = "ABC1234";
    for (int i = 3; i < POOL_KEYS; i++) key_pool[i] = {$urandom, $urandom};

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed
    push_op(kffst_pkg::FN_QUERY, 64'd0, 2'd0, 3'd0);
    push_op(kffst_pkg::FN_LOCATE, 64'd0, 2'd3, 3'd7);
    push_op(kffst_pkg::FN_RELEASE, 64'd0, 2'd0, 3'd0);
    push_op(kffst_pkg::FN_ALLOC, 64'd0, 2'd0, 3'd0);
    push_op(kffst_pkg::FN_ALLOC, '1, 2'd3, 3'd7);
    push_op(kffst_pkg::FN_ALLOC, 64'd0, 2'd0, 3'd0);
    push_op(kffst_pkg::FN_LOCATE, '1, 2'd0, 3'd0);
    push_op(kffst_pkg::FN_QUERY, '1, 2'd0, 3'd1);
    push_op(kffst_pkg::FN_QUERY, 64'd0, 2'd3, 3'd7);
    push_op(kffst_pkg::FN_RELEASE, 64'd0, 2'd0, 3'd0);
    push_op(kffst_pkg::FN_QUERY, 64'd0, 2'd0, 3'd0);
    push_op(kffst_pkg::FN_ALLOC, 64'h8000_0000_0000_0001, 2'd0, 3'd0);
    push_op(kffst_pkg::FN_LOCATE, 64'd0, 2'd0, 3'd0);
    push_op(kffst_pkg::FN_RELEASE, '1, 2'd0, 3'd0);
    push_op(kffst_pkg::FN_RELEASE, '1, 2'd0, 3'd0);
    push_op(kffst_pkg::FN_ALLOC, "ABC1234", 2'd0, 3'd0);
    push_op(kffst_pkg::FN_LOCATE, "ABC1234", 2'd0, 3'd0);
    push_op(kffst_pkg::FN_LOCATE, 64'h8000_0000_0000_0001, 2'd0, 3'd0);
    push_op(kffst_pkg::FN_QUERY, 64'd0, 2'd0, 3'd1);
    push_op(kffst_pkg::FN_RELEASE, "ABC1234", 2'd0, 3'd0);
    push_op(kffst_pkg::FN_RELEASE, 64'h8000_0000_0000_0001, 2'd0, 3'd0);
    wait_idle();

    // random phases: none, sender idle, receiver stall, both
    for (int p = 1; p <= 4; p++) begin
      phase_id = p;
      unique case (p)
        1: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        2: begin send_idle_pct = 45; recv_stall_pct = 0;  end
        3: begin send_idle_pct = 0;  recv_stall_pct = 45; end
        default: begin send_idle_pct = 24; recv_stall_pct = 24; end
      endcase
      for (int b = 0; b < BURST_ITEMS; b++) push_random_op(MODE_FILL);
      for (int b = 0; b < BURST_ITEMS; b++) push_random_op(MODE_MIX);
      for (int b = 0; b < BURST_ITEMS; b++) push_random_op(MODE_DRAIN);
      wait_idle();
    end

    guard = 0;
    while (guard < 40) begin
      @(posedge clk);
      guard++;
    end
    if (fail_cnt == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
